[design/jhdp_pkg.sv]
// ============================================================================
// jhdp_pkg
// Shared types, codes and helpers for the JPEG header dimension parser.
// ============================================================================
package jhdp_pkg;

    // Marker and fill byte values.
    localparam logic [7:0] BYTE_FILL    = 8'hFF;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] MARKER_SOI   = 8'hD8;
    localparam logic [7:0] MARKER_SOS   = 8'hDA;
    localparam logic [7:0] MARKER_SOF_LO = 8'hC0;
    localparam logic [7:0] MARKER_SOF_HI = 8'hCF;
    localparam logic [7:0] MARKER_DHT   = 8'hC4;
    localparam logic [7:0] MARKER_JPG   = 8'hC8;
    localparam logic [7:0] MARKER_DAC   = 8'hCC;

    // Smallest legal segment lengths.
    localparam logic [15:0] MIN_SEG_LEN = 16'd2;
    localparam logic [15:0] MIN_SOF_LEN = 16'd8;

    // Number of SOF header bytes read before the rest is skipped.
    localparam logic [2:0] SOF_FIELD_COUNT = 3'd6;

    // SOF header byte positions.
    localparam logic [2:0] SOF_HEIGHT_HI = 3'd1;
    localparam logic [2:0] SOF_HEIGHT_LO = 3'd2;
    localparam logic [2:0] SOF_WIDTH_HI  = 3'd3;
    localparam logic [2:0] SOF_WIDTH_LO  = 3'd4;
    localparam logic [2:0] SOF_CHANNELS  = 3'd5;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SOI     = 3'd1,
        ST_BAD_MARKER = 3'd2,
        ST_NO_SOF     = 3'd3,
        ST_TRUNC      = 3'd4,
        ST_BAD_LEN    = 3'd5
    } status_t;

    // Parse phases, one-hot.
    typedef enum logic [7:0] {
        PH_SOI0  = 8'b0000_0001,
        PH_SOI1  = 8'b0000_0010,
        PH_MARK0 = 8'b0000_0100,
        PH_MARK1 = 8'b0000_1000,
        PH_LENHI = 8'b0001_0000,
        PH_LENLO = 8'b0010_0000,
        PH_SOF   = 8'b0100_0000,
        PH_SKIP  = 8'b1000_0000
    } phase_t;

    // Complete parser state carried from byte to byte.
    typedef struct packed {
        phase_t      phase;
        logic [15:0] seg_remaining;
        logic [7:0]  length_high;
        logic [2:0]  field_index;
        logic [7:0]  marker;
        logic [15:0] height;
        logic [15:0] width;
        logic [7:0]  channels;
        logic [7:0]  frame_type;
        logic        shape_seen;
        logic        result_given;
    } parse_state_t;

    // One result item.
    typedef struct packed {
        status_t     status;
        logic [15:0] image_height;
        logic [15:0] image_width;
        logic [7:0]  channel_count;
        logic [7:0]  frame_type;
    } result_t;

    localparam parse_state_t PARSE_CLEAR = '{
        phase:         PH_SOI0,
        seg_remaining: 16'd0,
        length_high:   8'd0,
        field_index:   3'd0,
        marker:        8'd0,
        height:        16'd0,
        width:         16'd0,
        channels:      8'd0,
        frame_type:    8'd0,
        shape_seen:    1'b0,
        result_given:  1'b0
    };

    // True for start-of-frame marker codes.
    function automatic logic is_sof_code(input logic [7:0] code);
        logic in_range;
        logic excluded;
        in_range = (code >= MARKER_SOF_LO) && (code <= MARKER_SOF_HI);
        excluded = (code == MARKER_DHT) || (code == MARKER_JPG) || (code == MARKER_DAC);
        return in_range && !excluded;
    endfunction

endpackage

[design/jhdp_step.sv]
// ============================================================================
// jhdp_step
// Combinational next-state logic: consumes one stream byte against the
// current parser state and decides whether a result is produced.
// ============================================================================
module jhdp_step (
    input  jhdp_pkg::parse_state_t cur_state,
    input  logic [7:0]             data_byte,
    input  logic                   first_byte,
    input  logic                   last_byte,
    output jhdp_pkg::parse_state_t next_state,
    output logic                   emit,
    output jhdp_pkg::result_t      result
);
    import jhdp_pkg::*;

    parse_state_t s;
    parse_state_t nxt;
    status_t      st;
    logic         fire;
    logic [15:0]  seg_len;
    logic [15:0]  body_len;
    logic [15:0]  rem_dec;
    logic [2:0]   idx_inc;
    logic         sof;
    logic         ok;

    // Per-byte parse step.
    always_comb
    begin
        s        = first_byte ? PARSE_CLEAR : cur_state;
        nxt      = s;
        st       = ST_OK;
        fire     = 1'b0;
        seg_len  = {s.length_high, data_byte};
        body_len = seg_len - MIN_SEG_LEN;
        rem_dec  = s.seg_remaining - 16'd1;
        idx_inc  = s.field_index + 3'd1;
        sof      = is_sof_code(s.marker);

        if (!s.result_given)
        begin
            case (s.phase)
                PH_SOI0:
                begin
                    if (data_byte != BYTE_FILL)
                    begin
                        fire = 1'b1;
                        st   = ST_NO_SOI;
                    end
                    else
                    begin
                        nxt.phase = PH_SOI1;
                    end
                end
                PH_SOI1:
                begin
                    if (data_byte != MARKER_SOI)
                    begin
                        fire = 1'b1;
                        st   = ST_NO_SOI;
                    end
                    else
                    begin
                        nxt.phase = PH_MARK0;
                    end
                end
                PH_MARK0:
                begin
                    nxt.marker = data_byte;
                    nxt.phase  = PH_MARK1;
                end
                PH_MARK1:
                begin
                    // Fill bytes leave the phase unchanged.
                    if (data_byte != BYTE_FILL)
                    begin
                        if (s.marker != BYTE_FILL || data_byte == BYTE_ZERO)
                        begin
                            fire = 1'b1;
                            st   = ST_BAD_MARKER;
                        end
                        else
                        begin
                            nxt.marker = data_byte;
                            if (data_byte == MARKER_SOS)
                            begin
                                fire = 1'b1;
                                st   = s.shape_seen ? ST_OK : ST_NO_SOF;
                            end
                            else
                            begin
                                nxt.phase = PH_LENHI;
                            end
                        end
                    end
                end
                PH_LENHI:
                begin
                    nxt.length_high = data_byte;
                    nxt.phase       = PH_LENLO;
                end
                PH_LENLO:
                begin
                    if (seg_len < MIN_SEG_LEN || (sof && seg_len < MIN_SOF_LEN))
                    begin
                        fire = 1'b1;
                        st   = ST_BAD_LEN;
                    end
                    else
                    begin
                        nxt.seg_remaining = body_len;
                        if (sof)
                        begin
                            nxt.frame_type  = s.marker;
                            nxt.field_index = 3'd0;
                            nxt.phase       = PH_SOF;
                        end
                        else
                        begin
                            nxt.phase = (body_len == 16'd0) ? PH_MARK0 : PH_SKIP;
                        end
                    end
                end
                PH_SOF:
                begin
                    case (s.field_index)
                        SOF_HEIGHT_HI: nxt.height[15:8] = data_byte;
                        SOF_HEIGHT_LO: nxt.height[7:0]  = data_byte;
                        SOF_WIDTH_HI:  nxt.width[15:8]  = data_byte;
                        SOF_WIDTH_LO:  nxt.width[7:0]   = data_byte;
                        SOF_CHANNELS:
                        begin
                            nxt.channels   = data_byte;
                            nxt.shape_seen = 1'b1;
                        end
                        default: ;
                    endcase
                    nxt.seg_remaining = rem_dec;
                    nxt.field_index   = idx_inc;
                    if (idx_inc >= SOF_FIELD_COUNT)
                    begin
                        nxt.phase = (rem_dec == 16'd0) ? PH_MARK0 : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    nxt.seg_remaining = rem_dec;
                    if (rem_dec == 16'd0)
                    begin
                        nxt.phase = PH_MARK0;
                    end
                end
                default: ;
            endcase

            // A final byte that leaves the parse open reports truncation.
            if (!fire && last_byte)
            begin
                fire = 1'b1;
                st   = ST_TRUNC;
            end

            if (fire)
            begin
                nxt.result_given = 1'b1;
            end
        end
    end

    // Result payload: the held shape only on success.
    assign ok                   = (st == ST_OK);
    assign result.status        = st;
    assign result.image_height  = ok ? s.height     : 16'd0;
    assign result.image_width   = ok ? s.width      : 16'd0;
    assign result.channel_count = ok ? s.channels   : 8'd0;
    assign result.frame_type    = ok ? s.frame_type : 8'd0;
    assign next_state           = nxt;
    assign emit                 = fire;

endmodule

[design/jhdp_out_reg.sv]
// ============================================================================
// jhdp_out_reg
// Result register: holds one result request until the consumer takes it.
// ============================================================================
module jhdp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  jhdp_pkg::result_t load_data,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              space,
    output jhdp_pkg::result_t data
);
    import jhdp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can take a new result when empty or being drained.
    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign data      = data_reg;

endmodule

[design/jpeg_header_dimension_parser.sv]
// ============================================================================
// jpeg_header_dimension_parser
// Byte-serial JPEG marker parser that reports image shape at start of scan.
// ============================================================================
// Takes one stream byte per cycle, back to back, and reports at most one
// result per image: the height, width, component count and frame type from
// the last SOF segment once SOS arrives, or an error status. A byte passes
// an input register, then the combinational parse logic against the running
// parser state, and any result lands in an output register when the staged
// byte moves on; the consumer takes it from that register. Throughput is
// one byte per cycle. It drops whenever the output register holds a result
// that the consumer does not take in that cycle: the staged byte then waits,
// whether or not it would produce a result, and the input stalls behind it.
// Bytes after a result are ignored until a byte flagged first_byte.
module jpeg_header_dimension_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] image_height,
    output logic [15:0] image_width,
    output logic [7:0]  channel_count,
    output logic [7:0]  frame_type
);
    import jhdp_pkg::*;

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   byte_reg;
    logic         first_reg;
    logic         last_reg;
    logic         advance;
    logic         out_space;
    logic         emit;
    logic         load;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      step_result;
    result_t      out_data;

    // The staged byte moves on whenever the result register has room.
    assign advance  = in_valid_reg && out_space;
    assign in_ready = !in_valid_reg || advance;
    assign load     = advance && emit;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Input register: control bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Input register: payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= data_byte;
            first_reg <= first_byte;
            last_reg  <= last_byte;
        end
    end

    // Parse step.
    jhdp_step u_step (
        .cur_state  (state_reg),
        .data_byte  (byte_reg),
        .first_byte (first_reg),
        .last_byte  (last_reg),
        .next_state (state_next),
        .emit       (emit),
        .result     (step_result)
    );

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_CLEAR;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    jhdp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (step_result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .space     (out_space),
        .data      (out_data)
    );

    assign status        = out_data.status;
    assign image_height  = out_data.image_height;
    assign image_width   = out_data.image_width;
    assign channel_count = out_data.channel_count;
    assign frame_type    = out_data.frame_type;

    // A result always leaves the parser in its done state.
    a_result_closes_parse: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> state_reg.result_given)
        else $error("parser state not closed after a result");

    // No second result for the same image.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.result_given && !first_reg) |-> !emit)
        else $error("second result without a new image");

    // Error results carry no shape.
    a_error_zero_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (load && step_result.status != ST_OK) |->
            (step_result.image_height == 16'd0 && step_result.image_width == 16'd0
             && step_result.channel_count == 8'd0 && step_result.frame_type == 8'd0))
        else $error("error result carries shape data");

    // A success is only reported after a frame header was read.
    a_ok_needs_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (load && step_result.status == ST_OK) |-> (state_reg.shape_seen && !first_reg))
        else $error("success reported without a frame header");

endmodule
